// ===== rtl/elp_pkg.sv =====
// ----------------------------------------------------------------------------
// elp_pkg: shared types and constants of the edge list text parser
// Holds the byte codes, the token format that crosses the queue and the
// result kind codes.
// ----------------------------------------------------------------------------
package elp_pkg;

  localparam int NODE_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_NODE_BITS   = 32;

  localparam logic [7:0] CHR_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CHR_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CHR_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CHR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'

  typedef enum logic [2:0] {
    TOK_DIGIT,
    TOK_COMMA,
    TOK_CLOSE,
    TOK_OPEN,
    TOK_SPACE,
    TOK_OTHER
  } tok_class_t;

  typedef struct packed {
    tok_class_t  cls;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef enum logic [1:0] {
    MODE_INITIAL  = 2'd0,
    MODE_OUTER    = 2'd1,
    MODE_INNER    = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_EDGE        = 3'd0,
    KIND_CLOSED      = 3'd1,
    KIND_BAD_SYMBOL  = 3'd2,
    KIND_TOO_MANY    = 3'd3,
    KIND_WRONG_COUNT = 3'd4
  } kind_t;

  localparam int ENDS_BITS = 2;
  localparam logic [ENDS_BITS-1:0] ENDS_NONE = 2'd0;
  localparam logic [ENDS_BITS-1:0] ENDS_ONE  = 2'd1;
  localparam logic [ENDS_BITS-1:0] ENDS_TWO  = 2'd2;

endpackage

// ===== rtl/elp_front.sv =====
// ----------------------------------------------------------------------------
// elp_front: byte classifier
// Turns one text byte into a token: its class, its digit value and the
// end-of-stream mark.
// ----------------------------------------------------------------------------
module elp_front (
  input  logic            [7:0] byte_in,
  input  logic                  last_byte,
  output elp_pkg::token_t       token
);

  always_comb begin
    token.digit = 4'(byte_in - elp_pkg::CHR_ZERO);
    token.last  = last_byte;
    unique case (byte_in) inside
      [elp_pkg::CHR_ZERO:elp_pkg::CHR_NINE]: token.cls = elp_pkg::TOK_DIGIT;
      elp_pkg::CHR_COMMA:                    token.cls = elp_pkg::TOK_COMMA;
      elp_pkg::CHR_CLOSE:                    token.cls = elp_pkg::TOK_CLOSE;
      elp_pkg::CHR_OPEN:                     token.cls = elp_pkg::TOK_OPEN;
      elp_pkg::CHR_SPACE:                    token.cls = elp_pkg::TOK_SPACE;
      default:                               token.cls = elp_pkg::TOK_OTHER;
    endcase
  end

endmodule

// ===== rtl/elp_queue.sv =====
// ----------------------------------------------------------------------------
// elp_queue: token queue
// Small first-in first-out buffer between the classifier and the parser.
// ----------------------------------------------------------------------------
module elp_queue #(
  parameter int DEPTH = elp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  elp_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output elp_pkg::token_t head_tok
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  elp_pkg::token_t       slot_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_tok  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== rtl/elp_back.sv =====
// ----------------------------------------------------------------------------
// elp_back: parser core
// Walks the token stream through the list grammar, builds the node numbers
// and registers one result per edge, list close or error.
// ----------------------------------------------------------------------------
module elp_back #(
  parameter int NODE_BITS = elp_pkg::NODE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               tok_valid,
  input  elp_pkg::token_t                    tok,
  output logic                               tok_take,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [2:0]                         res_kind,
  output logic [elp_pkg::OUT_NODE_BITS-1:0]  res_node_a,
  output logic [elp_pkg::OUT_NODE_BITS-1:0]  res_node_b
);

  localparam int WIDE_BITS = NODE_BITS + 4;
  localparam logic [NODE_BITS-1:0] NODE_MAX = {NODE_BITS{1'b1}};

  elp_pkg::mode_t                  mode_r, mode_nxt;
  logic [NODE_BITS-1:0]            acc_r, acc_nxt;
  logic [NODE_BITS-1:0]            first_r, first_nxt;
  logic [NODE_BITS-1:0]            second_r, second_nxt;
  logic [elp_pkg::ENDS_BITS-1:0]   ends_r, ends_nxt;
  logic                            seen_r, seen_nxt;

  logic                            emit;
  elp_pkg::kind_t                  emit_kind;
  logic [NODE_BITS-1:0]            emit_a, emit_b;
  logic                            too_many;
  logic [WIDE_BITS-1:0]            acc_wide;
  logic                            out_free;

  logic                                res_valid_r;
  elp_pkg::kind_t                      res_kind_r;
  logic [elp_pkg::OUT_NODE_BITS-1:0]   res_node_a_r, res_node_b_r;

  assign out_free = !res_valid_r || !res_stall;
  assign tok_take = tok_valid && out_free;

  // acc * 10 + digit, wide enough to see overflow past the node range
  assign acc_wide = (WIDE_BITS'(acc_r) << 3) + (WIDE_BITS'(acc_r) << 1)
                  + WIDE_BITS'(tok.digit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= elp_pkg::MODE_INITIAL;
      acc_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      ends_r   <= elp_pkg::ENDS_NONE;
      seen_r   <= 1'b0;
    end else if (tok_take) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      ends_r   <= ends_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    ends_nxt   = ends_r;
    seen_nxt   = seen_r;
    emit       = 1'b0;
    emit_kind  = elp_pkg::KIND_EDGE;
    emit_a     = '0;
    emit_b     = '0;
    too_many   = 1'b0;

    unique case (mode_r)
      elp_pkg::MODE_INITIAL: begin
        if (tok.cls == elp_pkg::TOK_OPEN) begin
          mode_nxt = elp_pkg::MODE_OUTER;
        end
      end
      elp_pkg::MODE_OUTER: begin
        case (tok.cls) inside
          elp_pkg::TOK_OPEN: begin
            mode_nxt = elp_pkg::MODE_INNER;
          end
          elp_pkg::TOK_CLOSE: begin
            mode_nxt  = elp_pkg::MODE_FINISHED;
            emit      = 1'b1;
            emit_kind = elp_pkg::KIND_CLOSED;
          end
          elp_pkg::TOK_SPACE, elp_pkg::TOK_COMMA: begin
          end
          default: begin
            mode_nxt  = elp_pkg::MODE_FINISHED;
            emit      = 1'b1;
            emit_kind = elp_pkg::KIND_BAD_SYMBOL;
          end
        endcase
      end
      elp_pkg::MODE_INNER: begin
        if (tok.cls == elp_pkg::TOK_DIGIT) begin
          acc_nxt  = (|acc_wide[WIDE_BITS-1:NODE_BITS]) ? NODE_MAX
                                                        : acc_wide[NODE_BITS-1:0];
          seen_nxt = 1'b1;
        end else begin
          // close the pending number on a separator
          if ((tok.cls == elp_pkg::TOK_COMMA || tok.cls == elp_pkg::TOK_CLOSE) && seen_r) begin
            seen_nxt = 1'b0;
            case (ends_r)
              elp_pkg::ENDS_NONE: begin
                first_nxt = acc_r;
                ends_nxt  = elp_pkg::ENDS_ONE;
                acc_nxt   = '0;
              end
              elp_pkg::ENDS_ONE: begin
                second_nxt = acc_r;
                ends_nxt   = elp_pkg::ENDS_TWO;
                acc_nxt    = '0;
              end
              default: begin
                too_many  = 1'b1;
                mode_nxt  = elp_pkg::MODE_FINISHED;
                emit      = 1'b1;
                emit_kind = elp_pkg::KIND_TOO_MANY;
              end
            endcase
          end
          if (tok.cls == elp_pkg::TOK_CLOSE && !too_many) begin
            emit = 1'b1;
            if (ends_nxt != elp_pkg::ENDS_TWO) begin
              mode_nxt  = elp_pkg::MODE_FINISHED;
              emit_kind = elp_pkg::KIND_WRONG_COUNT;
            end else begin
              emit_kind  = elp_pkg::KIND_EDGE;
              emit_a     = first_nxt;
              emit_b     = second_nxt;
              first_nxt  = '0;
              second_nxt = '0;
              ends_nxt   = elp_pkg::ENDS_NONE;
              mode_nxt   = elp_pkg::MODE_OUTER;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // end of stream: drop all parse state after this byte
    if (tok.last) begin
      mode_nxt   = elp_pkg::MODE_INITIAL;
      acc_nxt    = '0;
      first_nxt  = '0;
      second_nxt = '0;
      ends_nxt   = elp_pkg::ENDS_NONE;
      seen_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= tok_take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && emit) begin
      res_kind_r   <= emit_kind;
      res_node_a_r <= elp_pkg::OUT_NODE_BITS'(emit_a);
      res_node_b_r <= elp_pkg::OUT_NODE_BITS'(emit_b);
    end
  end

  assign res_valid  = res_valid_r;
  assign res_kind   = res_kind_r;
  assign res_node_a = res_node_a_r;
  assign res_node_b = res_node_b_r;

endmodule

// ===== rtl/edge_list_text_parser.sv =====
// ----------------------------------------------------------------------------
// edge_list_text_parser: streaming parser for [[a,b],[c,d]] edge lists
// Byte-in, result-out parser with a classifier, a token queue and a parser
// core.
// ----------------------------------------------------------------------------
// Feed the text one byte per transfer on the in_ channel and mark the final
// byte with in_last_byte; after that byte the parser is back in its initial
// state, ready for the next text. The block sustains one byte per clock while
// neither out_stall nor a full queue holds it: the classifier writes a token
// into a small queue in the cycle the byte is accepted, and the parser core
// retires one token per cycle unless a stalled result holds it, with a single
// saturating multiply-by-ten-and-add as its longest path. With the queue
// empty, the token enters the queue at the accepting edge and the result
// register loads when the parser core takes that token from the queue. Each
// byte yields at most one result transfer: an edge with its two node numbers,
// a list close, or an error code; node fields are zero for everything but an
// edge. Node numbers saturate at 2^NODE_BITS - 1 and the ports carry their low
// 32 bits. A stall on out_ holds the result register and the parser core; the
// queue keeps taking bytes until it fills, and only then does in_stall rise.
// ----------------------------------------------------------------------------
module edge_list_text_parser #(
  parameter int NODE_BITS   = elp_pkg::NODE_BITS_DEF,
  parameter int QUEUE_DEPTH = elp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_node_a,
  output logic [31:0] out_node_b
);

  elp_pkg::token_t in_tok;
  elp_pkg::token_t head_tok;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            in_xfer;

  // a byte transfer happens whenever a byte is valid and the queue has room
  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  // classify the byte on the way into the queue
  elp_front u_front (
    .byte_in   (in_byte_in),
    .last_byte (in_last_byte),
    .token     (in_tok)
  );

  // decouple byte intake from the parser core
  elp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_tok  (in_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  // advance the grammar and register results
  elp_back #(
    .NODE_BITS (NODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (q_not_empty),
    .tok        (head_tok),
    .tok_take   (q_pop),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res_kind   (out_kind),
    .res_node_a (out_node_a),
    .res_node_b (out_node_b)
  );

endmodule

// ===== rtl/elp_checker.sv =====
// ----------------------------------------------------------------------------
// elp_checker: port-level checks of the edge list text parser
// Watches the result channel and the reset behavior of both channels.
// ----------------------------------------------------------------------------
module elp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [31:0] out_node_a,
  input logic [31:0] out_node_b
);

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= elp_pkg::KIND_WRONG_COUNT))
    else $error("result kind out of range");

  a_nodes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != elp_pkg::KIND_EDGE) |-> (out_node_a == '0 && out_node_b == '0))
    else $error("non-edge result carries node numbers");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind)
                                  && $stable(out_node_a) && $stable(out_node_b)))
    else $error("stalled result changed");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled with an empty queue after reset");

endmodule

bind edge_list_text_parser elp_checker u_elp_checker (.*);
